FILE: rtl/spq_pkg.sv
// Package of the stable priority queue: sizes, command and status codes,
// and the packed types of the request and response beats.
// No dependencies.
package spq_pkg;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned PAYLOAD_BITS = 32;
  localparam int unsigned CNT_W        = $clog2(DEPTH + 1);

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef logic [PAYLOAD_BITS-1:0] spq_data_t;

  typedef struct packed {
    logic        action;
    logic [31:0] payload;
    logic [7:0]  priority_req;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        head_valid;
    logic [31:0] head_payload;
    logic [7:0]  head_priority;
    logic [4:0]  entry_total;
  } spq_out_t;

  typedef struct packed {
    logic      valid;
    logic [7:0] prio;
    spq_data_t data;
  } spq_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } spq_cmd_t;

endpackage

FILE: rtl/spq_cell.sv
// One slot of the sorted shift chain of the stable priority queue.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  spq_cmd_t   cmd_i,
  input  spq_entry_t new_i,
  input  spq_entry_t left_i,
  input  logic       left_keep_i,
  input  spq_entry_t right_i,
  output spq_entry_t ent_o,
  output logic       keep_o
);

  logic       valid_q, valid_d;
  logic [7:0] prio_q, prio_d;
  spq_data_t  data_q, data_d;

  // A stored entry of equal or higher priority stays ahead of the new one.
  assign keep_o = valid_q && (prio_q >= new_i.prio);

  always_comb begin
    valid_d = valid_q;
    prio_d  = prio_q;
    data_d  = data_q;
    if (cmd_i.push && !keep_o) begin
      if (left_keep_i) begin
        valid_d = 1'b1;
        prio_d  = new_i.prio;
        data_d  = new_i.data;
      end else begin
        valid_d = left_i.valid;
        prio_d  = left_i.prio;
        data_d  = left_i.data;
      end
    end else if (cmd_i.pop) begin
      valid_d = right_i.valid;
      prio_d  = right_i.prio;
      data_d  = right_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    data_q <= data_d;
  end

  assign ent_o = '{valid: valid_q, prio: prio_q, data: data_q};

endmodule

FILE: rtl/stable_priority_queue_unit.sv
// Top level of the stable priority queue: a chain of sorted cells plus
// the entry counter and the response register. Depends on spq_pkg, spq_cell.
//
// A request beat (push of a payload with a priority, or pop of the head)
// is taken at a rising edge where start is high and busy is low. Busy is
// never raised, so one beat can be taken in every cycle. The response beat
// appears on rsp_o in the following cycle, marked by done_o for exactly one cycle;
// the receiver cannot hold it off and must take it then.
// Throughput is one beat per cycle: every cell compares its stored priority
// with the pushed one in parallel and shifts toward or away from the head
// in the same cycle, so the update is one compare plus a select per cell.
// Entries of equal priority leave in arrival order. A push to a full queue
// is dropped with status FULL; a pop of an empty queue reports EMPTY.
// Each response carries the head entry and the entry count after the beat.
// Reset clears all cell valid bits and the count; the queue is empty and
// ready in the first cycle after reset.
module stable_priority_queue_unit import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  spq_in_t  req_i,
  output logic     done_o,
  output spq_out_t rsp_o
);

  logic             accept;
  logic             full, empty;
  spq_cmd_t         cmd;
  spq_entry_t       new_ent;
  spq_entry_t       ent  [DEPTH];
  logic             keep [DEPTH];
  logic [DEPTH-1:0] valid_vec;
  logic [CNT_W-1:0] count_q, count_d;
  logic [1:0]       status_q, status_d;
  logic             done_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);

  assign cmd.push = accept && (req_i.action == ACT_PUSH) && !full;
  assign cmd.pop  = accept && (req_i.action == ACT_POP) && !empty;

  assign new_ent = '{valid: 1'b1, prio: req_i.priority_req,
                     data: spq_data_t'(req_i.payload)};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_entry_t left_ent, right_ent;
    logic       left_keep;
    if (i == 0) begin : g_first
      assign left_ent  = '0;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left_ent  = ent[i-1];
      assign left_keep = keep[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end
    spq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .new_i      (new_ent),
      .left_i     (left_ent),
      .left_keep_i(left_keep),
      .right_i    (right_ent),
      .ent_o      (ent[i]),
      .keep_o     (keep[i])
    );
    assign valid_vec[i] = ent[i].valid;
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_DONE;
    if (accept) begin
      if (req_i.action == ACT_PUSH) begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end else begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
  end

  assign done_o             = done_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.head_valid   = ent[0].valid;
  assign rsp_o.head_payload = ent[0].valid ? 32'(ent[0].data) : 32'd0;
  assign rsp_o.head_priority = ent[0].valid ? ent[0].prio : 8'd0;
  assign rsp_o.entry_total  = 5'(count_q);

  a_count_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == $countones(valid_vec))
    else $error("Entry count does not match the occupied cells.");

  a_valid_packed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + DEPTH'(1))) == '0)
    else $error("Occupied cells are not packed toward the head.");

  a_beat_answered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("Accepted beat produced no response.");

  a_full_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_FULL) |-> count_q == CNT_W'(DEPTH))
    else $error("Push reported as dropped while the queue is not full.");

  a_empty_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_EMPTY) |-> !ent[0].valid)
    else $error("Pop reported as empty while the queue holds entries.");

endmodule

FILE: tb/stable_priority_queue_unit_checker.sv
// Checker of the stable priority queue: keeps its own sorted copy of the queue,
// predicts the response beat of every accepted request and compares the
// response beats in order. Depends on spq_pkg.
module stable_priority_queue_unit_checker import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     busy,
  input  spq_in_t  req_i,
  input  logic     done_o,
  input  spq_out_t rsp_o,
  output int       fail_count_o,
  output int       pending_o
);

  logic [31:0] shadow_data [DEPTH];
  logic [7:0]  shadow_prio [DEPTH];
  int unsigned shadow_count = 0;
  spq_out_t    rsp_fifo [$];
  spq_out_t    oldest_rsp;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic spq_out_t apply_request(spq_in_t beat);
    spq_out_t    rsp;
    int unsigned pos;
    rsp = '0;
    rsp.status = ST_DONE;
    if (beat.action == ACT_PUSH) begin
      if (shadow_count >= DEPTH) begin
        rsp.status = ST_FULL;
      end else begin
        pos = shadow_count;
        for (int unsigned i = 0; i < shadow_count; i++) begin
          if (shadow_prio[i] < beat.priority_req) begin
            pos = i;
            break;
          end
        end
        for (int unsigned i = shadow_count; i > pos; i--) begin
          shadow_data[i] = shadow_data[i-1];
          shadow_prio[i] = shadow_prio[i-1];
        end
        shadow_data[pos] = beat.payload;
        shadow_prio[pos] = beat.priority_req;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        rsp.status = ST_EMPTY;
      end else begin
        for (int unsigned i = 1; i < shadow_count; i++) begin
          shadow_data[i-1] = shadow_data[i];
          shadow_prio[i-1] = shadow_prio[i];
        end
        shadow_count--;
      end
    end
    if (shadow_count > 0) begin
      rsp.head_valid    = 1'b1;
      rsp.head_payload  = shadow_data[0];
      rsp.head_priority = shadow_prio[0];
    end
    rsp.entry_total = shadow_count[4:0];
    return rsp;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        rsp_fifo.push_back(apply_request(req_i));
      end
      if (done_o) begin
        if (rsp_fifo.size() == 0) begin
          $display("%0t: response beat with none expected, actual %0h", $time, rsp_o);
          fail_count_o++;
        end else begin
          oldest_rsp = rsp_fifo.pop_front();
          check_field("status", 32'(oldest_rsp.status), 32'(rsp_o.status));
          check_field("head_valid", 32'(oldest_rsp.head_valid), 32'(rsp_o.head_valid));
          check_field("head_payload", oldest_rsp.head_payload, rsp_o.head_payload);
          check_field("head_priority", 32'(oldest_rsp.head_priority),
                      32'(rsp_o.head_priority));
          check_field("entry_total", 32'(oldest_rsp.entry_total), 32'(rsp_o.entry_total));
        end
      end
      pending_o <= rsp_fifo.size();
    end
  end

endmodule

FILE: tb/stable_priority_queue_unit_tb.sv
// Testbench top of the stable priority queue: clock, reset, request stimulus
// with random gaps, a stall watchdog and the verdict.
// Depends on spq_pkg, stable_priority_queue_unit and its checker.
module stable_priority_queue_unit_tb;
  import spq_pkg::*;

  localparam int RANDOM_BEATS = 1200;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     start;
  logic     busy;
  spq_in_t  req_i;
  logic     done_o;
  spq_out_t rsp_o;
  int       fail_count;
  int       pending;
  int       stall_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  stable_priority_queue_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  stable_priority_queue_unit_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .done_o       (done_o),
    .rsp_o        (rsp_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic spq_in_t push_beat(logic [7:0] prio, logic [31:0] data);
    spq_in_t beat;
    beat.action       = ACT_PUSH;
    beat.payload      = data;
    beat.priority_req = prio;
    return beat;
  endfunction

  function automatic spq_in_t pop_beat(logic [7:0] prio, logic [31:0] data);
    spq_in_t beat;
    beat.action       = ACT_POP;
    beat.payload      = data;
    beat.priority_req = prio;
    return beat;
  endfunction

  function automatic logic [7:0] pick_priority();
    if ($urandom_range(0, 99) < 70) begin
      return 8'($urandom_range(0, 3));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_beat(input spq_in_t beat, input bit may_idle);
    bit taken;
    while (may_idle && $urandom_range(0, 99) < 20) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= beat;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
  endtask

  initial begin
    int push_pct;
    bit may_idle;
    rst_ni <= 1'b0;
    start  <= 1'b0;
    req_i  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty pop, extreme priorities and payloads, ties at both
    // ends, a fill to capacity and a push into the full queue.
    send_beat(pop_beat(8'hff, 32'hffff_ffff), 1'b1);
    send_beat(push_beat(8'h00, 32'h0000_0000), 1'b1);
    send_beat(push_beat(8'hff, 32'hffff_ffff), 1'b1);
    send_beat(push_beat(8'hff, 32'h0000_0001), 1'b1);
    send_beat(push_beat(8'h00, 32'h0000_0002), 1'b1);
    send_beat(push_beat(8'h80, 32'ha5a5_a5a5), 1'b1);
    send_beat(pop_beat(8'h00, 32'h0000_0000), 1'b1);
    for (int i = 0; i < 12; i++) begin
      send_beat(push_beat(8'(i % 3 == 0 ? 8'hff : (i % 3 == 1 ? 8'h80 : 8'h07)),
                          32'h5a5a_0000 + i), 1'b1);
    end
    send_beat(push_beat(8'hc8, 32'hdead_beef), 1'b1);
    send_beat(pop_beat(8'h55, 32'h1234_5678), 1'b1);

    push_pct = 50;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 25;
          1: push_pct = 50;
          default: push_pct = 80;
        endcase
      end
      if (n == RANDOM_BEATS / 2) begin
        start <= 1'b0;
        do @(negedge clk_i); while (pending != 0);
        @(posedge clk_i);
      end
      may_idle = !(n >= 400 && n < 600);
      if ($urandom_range(0, 99) < push_pct) begin
        send_beat(push_beat(pick_priority(), $urandom()), may_idle);
      end else begin
        send_beat(pop_beat(8'($urandom_range(0, 255)), $urandom()), may_idle);
      end
    end

    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
